@@ rtl/core/hcbp_pkg.sv @@
package hcbp_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RES_W    = 7;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned NB_W     = 3;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned BUF_BYTES = 4;
  localparam int unsigned PAD_W    = 4;
  localparam int unsigned PAD_WRAP = 12;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

endpackage

@@ rtl/core/hcbp_req_if.sv @@
interface hcbp_req_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_word;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, operation, symbol, code_word, code_length, input ready);
  modport sink (input valid, operation, symbol, code_word, code_length, output ready);
endinterface

@@ rtl/core/hcbp_rsp_if.sv @@
interface hcbp_rsp_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              stream_end;

  modport source (output valid, out_byte, run_last, stream_end, input ready);
  modport sink (input valid, out_byte, run_last, stream_end, output ready);
endinterface

@@ rtl/core/huffman_code_bit_packer.sv @@
// Huffman bit packer. Takes one request per cycle while the byte buffer has room: load
// writes a symbol's code word and length into the code table, encode appends that
// symbol's code bits to the bit stream, flush pads the stream so the low nibble of the
// final byte holds the pad count and restarts it; a flush with no bits since the last
// emits nothing. Packed bytes leave one per cycle while the receiver is ready, earliest
// bit in the MSB. The table read and the request are registered on accept; the next
// stage packs and loads the byte buffer. A request yields at most 4 bytes (at most 2 for
// a flush), so one request a cycle is sustained only while bytes average at most one per
// request. Table entries power up empty; a symbol never loaded emits nothing.
module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned NUM_SYMBOLS  = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  hcbp_req_if.sink   req_i,
  hcbp_rsp_if.source rsp_o
);

  localparam int unsigned SymAw   = $clog2(NUM_SYMBOLS);
  localparam int unsigned CodeCap = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int unsigned EntW    = LEN_W + CODE_W;

  logic                  accept;
  logic                  in_range;
  logic [SymAw-1:0]      addr;
  logic [LEN_W-1:0]      len_sat;
  logic                  load_we;
  logic [EntW-1:0]       ram_rdata;
  logic [NUM_SYMBOLS-1:0] loaded_q;

  logic                  s1_vld_q, s1_vld_d;
  logic [OP_W-1:0]       s1_op_q;
  logic                  s1_hit_q;
  logic                  s1_adv;

  logic [RES_W-1:0]      res_q, res_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  seen_q, seen_d;

  logic [ACC_W-1:0]      ob_q;
  logic [NB_W-1:0]       ob_cnt_q;
  logic                  ob_end_q;
  logic                  pop;
  logic                  ob_free;

  logic [LEN_W-1:0]      len;
  logic [CODE_W-1:0]     code_m;
  logic                  do_enc, do_fl;
  logic [PAD_W-1:0]      pad;
  logic [ACC_W-1:0]      acc;
  logic [LEN_W-1:0]      total;
  logic [ACC_W-1:0]      aligned;
  logic [NB_W-1:0]       nbytes;

  assign accept   = req_i.valid && req_i.ready;
  assign in_range = {1'b0, req_i.symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
  assign addr     = req_i.symbol[SymAw-1:0];
  assign len_sat  = (req_i.code_length > LEN_W'(CodeCap)) ? LEN_W'(CodeCap)
                                                          : req_i.code_length;
  assign load_we  = accept && (req_i.operation == OP_LOAD) && in_range;

  hcbp_ram #(
    .WIDTH (EntW),
    .DEPTH (NUM_SYMBOLS)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (addr),
    .wdata_i ({len_sat, req_i.code_word}),
    .re_i    (accept),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else if (load_we) begin
      loaded_q[addr] <= 1'b1;
    end
  end

  // pack stage
  always_comb begin
    len     = s1_hit_q ? ram_rdata[EntW-1:CODE_W] : '0;
    code_m  = ram_rdata[CODE_W-1:0] & ~({CODE_W{1'b1}} << len);
    do_enc  = s1_vld_q && (s1_op_q == OP_ENCODE) && (len != '0);
    do_fl   = s1_vld_q && (s1_op_q == OP_FLUSH);
    pad     = (cnt_q <= CNT_W'(PAD_W)) ? (PAD_W'(PAD_W) - PAD_W'(cnt_q))
                                       : (PAD_W'(PAD_WRAP) - PAD_W'(cnt_q));
    if (do_fl) begin
      acc   = (ACC_W'(res_q) << (LEN_W'(pad) + LEN_W'(PAD_W))) | ACC_W'(pad);
      total = LEN_W'(cnt_q) + LEN_W'(pad) + LEN_W'(PAD_W);
    end else begin
      acc   = (ACC_W'(res_q) << len) | ACC_W'(code_m);
      total = LEN_W'(cnt_q) + len;
    end
    aligned = acc << (LEN_W'(ACC_W) - total);
    nbytes  = (do_enc || (do_fl && seen_q)) ? total[LEN_W-1:CNT_W] : '0;

    res_d  = res_q;
    cnt_d  = cnt_q;
    seen_d = seen_q;
    if (do_enc) begin
      cnt_d  = total[CNT_W-1:0];
      res_d  = acc[RES_W-1:0] & ~({RES_W{1'b1}} << total[CNT_W-1:0]);
      seen_d = 1'b1;
    end else if (do_fl) begin
      cnt_d  = '0;
      res_d  = '0;
      seen_d = 1'b0;
    end
  end

  assign pop         = rsp_o.valid && rsp_o.ready;
  assign ob_free     = (ob_cnt_q == '0) || ((ob_cnt_q == NB_W'(1)) && pop);
  assign s1_adv      = s1_vld_q && (ob_free || (nbytes == '0));
  assign req_i.ready = !s1_vld_q || s1_adv;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      res_q    <= '0;
      cnt_q    <= '0;
      seen_q   <= 1'b0;
      ob_cnt_q <= '0;
      ob_end_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      if (s1_adv) begin
        res_q  <= res_d;
        cnt_q  <= cnt_d;
        seen_q <= seen_d;
      end
      if (s1_adv && (nbytes != '0)) begin
        ob_cnt_q <= nbytes;
        ob_end_q <= do_fl;
      end else if (pop) begin
        ob_cnt_q <= ob_cnt_q - NB_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= req_i.operation;
      s1_hit_q <= in_range && loaded_q[addr];
    end
    if (s1_adv && (nbytes != '0)) begin
      ob_q <= aligned;
    end else if (pop) begin
      ob_q <= ob_q << BYTE_W;
    end
  end

  assign rsp_o.valid      = (ob_cnt_q != '0);
  assign rsp_o.out_byte   = ob_q[ACC_W-1 -: BYTE_W];
  assign rsp_o.run_last   = (ob_cnt_q == NB_W'(1));
  assign rsp_o.stream_end = ob_end_q && (ob_cnt_q == NB_W'(1));

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cnt_q <= NB_W'(BUF_BYTES))
    else $error("byte buffer count out of range");

  a_buf_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (nbytes != '0)) |-> ((ob_cnt_q == '0) || ((ob_cnt_q == NB_W'(1)) && pop)))
    else $error("byte buffer reloaded while bytes pending");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && do_fl) |=> ((cnt_q == '0) && !seen_q && (res_q == '0)))
    else $error("flush left packer state");

  a_residue_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((8'(res_q) >> cnt_q) == 8'd0))
    else $error("stale bits above residue count");

  a_count_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> seen_q)
    else $error("residue without any bits sent");

endmodule

@@ rtl/core/hcbp_ram.sv @@
module hcbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam int unsigned MAX_LEN     = 32;
  localparam int unsigned SYMBOLS     = 256;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_LEN    = 80;
  localparam int unsigned END_WAIT    = 20;

  // operation code with no function, ignored by the packer
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              stream_end;
  } packed_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hcbp_req_if req ();
  hcbp_rsp_if rsp ();

  huffman_code_bit_packer #(
    .MAX_CODE_LEN(MAX_LEN),
    .NUM_SYMBOLS (SYMBOLS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // packer model state
  logic [CODE_W-1:0] code_table [SYMBOLS];
  logic [LEN_W-1:0]  length_table [SYMBOLS] = '{default: '0};
  logic [RES_W-1:0]  residue_bits = '0;
  logic [CNT_W-1:0]  residue_len = '0;
  logic              stream_open = 1'b0;

  request_t     pending_reqs [$];
  packed_byte_t expected_bytes [$];
  logic [SYM_W-1:0] loaded_syms [$];
  logic             is_loaded [SYMBOLS] = '{default: 1'b0};

  request_t     next_req;
  packed_byte_t seen_byte;
  packed_byte_t want_byte;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_cycles = 0;

  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned byte_count = 0;
  int unsigned end_count = 0;
  int unsigned backpressure_cycles = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  task automatic push_bytes(input logic [ACC_W-1:0] acc, input int unsigned nbits,
                            input logic end_mark);
    int unsigned left;
    packed_byte_t b;
    left = nbits;
    while (left >= 8) begin
      left -= 8;
      b.out_byte = acc[left +: 8];
      b.run_last = (left < 8);
      b.stream_end = (left < 8) ? end_mark : 1'b0;
      expected_bytes.push_back(b);
    end
  endtask

  task automatic pack_request(input request_t r);
    logic [ACC_W-1:0] acc;
    int unsigned len;
    int unsigned total;
    int unsigned pad;
    case (r.operation)
      OP_LOAD: begin
        len = (r.code_length > MAX_LEN) ? MAX_LEN : r.code_length;
        code_table[r.symbol] = r.code_word;
        length_table[r.symbol] = len[LEN_W-1:0];
      end
      OP_ENCODE: begin
        len = length_table[r.symbol];
        if (len != 0) begin
          acc = (ACC_W'(residue_bits) << len) |
                (ACC_W'(code_table[r.symbol]) & ((ACC_W'(1) << len) - 1));
          total = residue_len + len;
          push_bytes(acc, total, 1'b0);
          residue_len = total[CNT_W-1:0];
          residue_bits = RES_W'(acc & ((ACC_W'(1) << residue_len) - 1));
          stream_open = 1'b1;
        end
      end
      OP_FLUSH: begin
        if (stream_open) begin
          pad = (residue_len <= PAD_W) ? PAD_W - residue_len : PAD_WRAP - residue_len;
          acc = (ACC_W'(residue_bits) << (pad + PAD_W)) | ACC_W'(pad);
          push_bytes(acc, residue_len + pad + PAD_W, 1'b1);
        end
        residue_bits = '0;
        residue_len = '0;
        stream_open = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic void add_request(input request_t r);
    if (r.operation == OP_LOAD && !is_loaded[r.symbol]) begin
      is_loaded[r.symbol] = 1'b1;
      loaded_syms.push_back(r.symbol);
    end
    pending_reqs.push_back(r);
    queued_count++;
  endfunction

  // mostly encodes of loaded symbols, with loads (always while none is loaded), flushes and noise
  function automatic request_t random_request();
    request_t r;
    int unsigned roll;
    int unsigned len_roll;
    roll = $urandom_range(99);
    len_roll = $urandom_range(99);
    r.symbol = SYM_W'($urandom_range(SYMBOLS - 1));
    r.code_word = $urandom;
    r.code_length = LEN_W'($urandom_range(63));
    if (loaded_syms.size() == 0 || roll < 15) begin
      r.operation = OP_LOAD;
      if (len_roll < 8) r.code_length = '0;
      else if (len_roll < 60) r.code_length = LEN_W'($urandom_range(8, 1));
      else if (len_roll < 88) r.code_length = LEN_W'($urandom_range(32, 9));
      else r.code_length = LEN_W'($urandom_range(63, 33));
    end else if (roll < 86) begin
      r.operation = OP_ENCODE;
      r.symbol = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
    end else if (roll < 96) begin
      r.operation = OP_FLUSH;
    end else begin
      r.operation = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic drain();
    while (accepted_count != queued_count || expected_bytes.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (pending_reqs.size() != 0 &&
          !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)) begin
        next_req = pending_reqs.pop_front();
        req.valid <= 1'b1;
        req.operation <= next_req.operation;
        req.symbol <= next_req.symbol;
        req.code_word <= next_req.code_word;
        req.code_length <= next_req.code_length;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      if (hold_cycles == HOLD_LEN) hold_done <= 1'b1;
      else hold_cycles <= hold_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        pack_request({req.operation, req.symbol, req.code_word, req.code_length});
        accepted_count++;
      end
      if (req.valid && !req.ready) backpressure_cycles++;
      if (rsp.valid && rsp.ready) begin
        seen_byte = {rsp.out_byte, rsp.run_last, rsp.stream_end};
        byte_count++;
        if (rsp.stream_end) end_count++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte %h with nothing pending", seen_byte.out_byte);
          error_count++;
        end else begin
          want_byte = expected_bytes.pop_front();
          if (seen_byte.out_byte !== want_byte.out_byte) begin
            $error("out_byte expected %h got %h", want_byte.out_byte, seen_byte.out_byte);
            error_count++;
          end
          if (seen_byte.run_last !== want_byte.run_last) begin
            $error("run_last expected %b got %b", want_byte.run_last, seen_byte.run_last);
            error_count++;
          end
          if (seen_byte.stream_end !== want_byte.stream_end) begin
            $error("stream_end expected %b got %b", want_byte.stream_end,
                   seen_byte.stream_end);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // flush on an empty stream, unused op, extreme codes and lengths, pad counts 3, 6, 0
    add_request({OP_FLUSH, 8'd0, 32'h0, 6'd0});
    add_request({OP_UNUSED, 8'hff, 32'hffff_ffff, 6'h3f});
    add_request({OP_LOAD, 8'd0, 32'h0000_0001, 6'd1});
    add_request({OP_LOAD, 8'd255, 32'hffff_ffff, 6'd32});
    add_request({OP_LOAD, 8'd128, 32'ha5a5_5a5a, 6'd63});
    add_request({OP_LOAD, 8'd7, 32'hffff_ffff, 6'd0});
    add_request({OP_LOAD, 8'd2, 32'hffff_ff55, 6'd7});
    add_request({OP_LOAD, 8'd1, 32'h0000_0000, 6'd33});
    add_request({OP_ENCODE, 8'd7, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd0, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd255, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd128, 32'h0, 6'd0});
    add_request({OP_FLUSH, 8'd0, 32'h0, 6'd0});
    add_request({OP_FLUSH, 8'd0, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd2, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd2, 32'h0, 6'd0});
    add_request({OP_FLUSH, 8'd0, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd1, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd0, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd0, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd0, 32'h0, 6'd0});
    add_request({OP_ENCODE, 8'd0, 32'h0, 6'd0});
    add_request({OP_FLUSH, 8'd0, 32'h0, 6'd0});
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk_i);
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      for (int i = 0; i < 43; i++) add_request(random_request());
      drain();
    end

    // receiver holds off while requests keep coming
    @(negedge clk_i);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b1;
    for (int i = 0; i < 24; i++) add_request(random_request());
    drain();

    repeat (END_WAIT) @(posedge clk_i);
    if (expected_bytes.size() != 0) begin
      $error("%0d bytes never arrived", expected_bytes.size());
      error_count++;
    end
    $display("run covered %0d requests, %0d packed bytes and %0d stream ends",
             accepted_count, byte_count, end_count);
    $display("input back-pressure seen on %0d cycles", backpressure_cycles);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
